### hdl/gac_pkg.sv
// ----------------------------------------------------------------------------
// gac_pkg
// shared types, constants and pulse helpers for the autofire controller
// ----------------------------------------------------------------------------
package gac_pkg;

  localparam int FIRE_BUTTONS_DEF = 6;
  localparam int HOLD_W           = 8;
  localparam int CNT_W            = HOLD_W + 1;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(2);

  localparam logic REG_HOLD_HIGH = 1'b0;
  localparam logic REG_HOLD_LOW  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_TURBO = 2'd1,
    MODE_AUTO  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_high;
    logic [HOLD_W-1:0] hold_low;
  } hold_cfg_t;

  typedef struct packed {
    logic step;
    logic active;
  } lane_ctl_t;

  function automatic logic pulse_level(logic [CNT_W-1:0] cnt, hold_cfg_t cfg);
    return cnt < {1'b0, cfg.hold_high};
  endfunction

  function automatic logic [CNT_W-1:0] pulse_next(logic [CNT_W-1:0] cnt, hold_cfg_t cfg);
    logic [CNT_W:0]   inc;
    logic [CNT_W-1:0] period;
    period = {1'b0, cfg.hold_high} + {1'b0, cfg.hold_low};
    inc    = {1'b0, cnt} + (CNT_W+1)'(1);
    if (inc >= {1'b0, period}) begin
      return '0;
    end
    return inc[CNT_W-1:0];
  endfunction

endpackage

### hdl/gac_cfg.sv
// ----------------------------------------------------------------------------
// gac_cfg
// register file for the pulse timing, written and read over the apb port
// ----------------------------------------------------------------------------
module gac_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [gac_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [gac_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [gac_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready,
  output gac_pkg::hold_cfg_t                 hold_cfg
);

  logic                           hold_high_sel;
  logic [gac_pkg::HOLD_W-1:0]     high_r;
  logic [gac_pkg::HOLD_W-1:0]     low_r;
  logic                           wr_en;
  logic                           reg_sel;

  assign cfg_pready    = 1'b1;
  assign reg_sel       = cfg_paddr[2];
  assign wr_en         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign hold_high_sel = (reg_sel == gac_pkg::REG_HOLD_HIGH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= gac_pkg::HOLD_RESET;
      low_r  <= gac_pkg::HOLD_RESET;
    end else if (wr_en) begin
      if (hold_high_sel) begin
        high_r <= cfg_pwdata[gac_pkg::HOLD_W-1:0];
      end else begin
        low_r <= cfg_pwdata[gac_pkg::HOLD_W-1:0];
      end
    end
  end

  always_comb begin
    case (reg_sel)
      gac_pkg::REG_HOLD_HIGH: cfg_prdata = gac_pkg::CFG_DATA_W'(high_r);
      gac_pkg::REG_HOLD_LOW:  cfg_prdata = gac_pkg::CFG_DATA_W'(low_r);
      default:                cfg_prdata = '0;
    endcase
  end

  assign hold_cfg.hold_high = high_r;
  assign hold_cfg.hold_low  = low_r;

endmodule

### hdl/gac_lane.sv
// ----------------------------------------------------------------------------
// gac_lane
// one fire button: mode switch edge detect, mode cycling and pulse counter
// ----------------------------------------------------------------------------
module gac_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gac_pkg::lane_ctl_t   ctl,
  input  gac_pkg::hold_cfg_t   hold_cfg,
  input  logic                 switch_bit,
  input  logic                 held_bit,
  output logic                 fire_bit,
  output logic [1:0]           mode
);

  gac_pkg::mode_t               mode_r;
  gac_pkg::mode_t               mode_nxt;
  logic [gac_pkg::CNT_W-1:0]    cnt_r;
  logic [gac_pkg::CNT_W-1:0]    cnt_nxt;
  logic                         prev_r;
  logic                         sw_edge;

  assign sw_edge = ctl.active & switch_bit & ~prev_r;

  // mode advances first, outputs use the new mode
  always_comb begin
    mode_nxt = mode_r;
    if (sw_edge) begin
      case (mode_r)
        gac_pkg::MODE_OFF:   mode_nxt = gac_pkg::MODE_TURBO;
        gac_pkg::MODE_TURBO: mode_nxt = gac_pkg::MODE_AUTO;
        default:             mode_nxt = gac_pkg::MODE_OFF;
      endcase
    end
  end

  always_comb begin
    fire_bit = held_bit;
    cnt_nxt  = cnt_r;
    case (mode_nxt)
      gac_pkg::MODE_TURBO: begin
        if (held_bit) begin
          fire_bit = gac_pkg::pulse_level(cnt_r, hold_cfg);
          cnt_nxt  = gac_pkg::pulse_next(cnt_r, hold_cfg);
        end else begin
          fire_bit = 1'b0;
          cnt_nxt  = '0;
        end
      end
      gac_pkg::MODE_AUTO: begin
        fire_bit = gac_pkg::pulse_level(cnt_r, hold_cfg);
        cnt_nxt  = gac_pkg::pulse_next(cnt_r, hold_cfg);
      end
      default: begin
        fire_bit = held_bit;
        cnt_nxt  = cnt_r;
      end
    endcase
  end

  assign mode = mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gac_pkg::MODE_OFF;
      cnt_r  <= '0;
      prev_r <= 1'b0;
    end else if (ctl.step) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      prev_r <= switch_bit;
    end
  end

endmodule

### hdl/gamepad_autofire_controller_unit.sv
// ----------------------------------------------------------------------------
// gamepad_autofire_controller_unit
// turbo and autofire processing of one gamepad poll per request
// ----------------------------------------------------------------------------
// Each poll request is registered on entry, then the lane logic forms the
// result and loads the output register. A new request is taken every clock
// while the output side keeps up, so throughput is one poll per cycle; the
// input register and the output register together let the pipe keep moving
// while a result waits. Turbo and auto pulses last hold_high polls on and
// hold_low polls off, set through the apb registers at byte addresses 0 and 4.
module gamepad_autofire_controller_unit #(
  parameter  int FIRE_BUTTONS = gac_pkg::FIRE_BUTTONS_DEF,
  localparam int IN_W         = 8 + 2 * FIRE_BUTTONS,
  localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W        = 7 + 3 * FIRE_BUTTONS,
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // dpad_raw, fire_raw, select_raw, start_raw, switch_raw, slow_raw, pad_active
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // dpad_out, fire_out, select_out, start_out, modes_out, slow_on
  output logic [OUT_TDATA_W-1:0]          out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gac_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [gac_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [gac_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int FB        = FIRE_BUTTONS;
  localparam int I_FIRE    = 4;
  localparam int I_SEL     = I_FIRE + FB;
  localparam int I_START   = I_SEL + 1;
  localparam int I_SW      = I_START + 1;
  localparam int I_SLOW    = I_SW + FB;
  localparam int I_ACT     = I_SLOW + 1;
  localparam int O_SLOW_ON = 7 + 3 * FB - 1;

  gac_pkg::hold_cfg_t           hold_cfg;
  gac_pkg::lane_ctl_t           lane_ctl;

  logic [IN_W-1:0]              in_data_r;
  logic                         in_valid_r;
  logic [OUT_W-1:0]             out_data_r;
  logic [OUT_W-1:0]             out_data_nxt;
  logic                         out_valid_r;
  logic                         adv;
  logic                         step;

  logic [3:0]                   dpad;
  logic [FB-1:0]                fire;
  logic                         sel;
  logic                         start;
  logic [FB-1:0]                sw;
  logic                         slow;
  logic                         active;

  logic [FB-1:0]                fire_res;
  logic [2*FB-1:0]              modes;

  logic                         slow_en_r;
  logic                         slow_en_nxt;
  logic [gac_pkg::CNT_W-1:0]    slow_cnt_r;
  logic [gac_pkg::CNT_W-1:0]    slow_cnt_nxt;
  logic                         prev_slow_r;
  logic                         slow_pulse;

  gac_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .hold_cfg    (hold_cfg)
  );

  // pipeline handshake
  assign adv       = ~out_valid_r | out_tready;
  assign step      = adv & in_valid_r;
  assign in_tready = ~in_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready & in_tvalid) begin
      in_data_r <= in_tdata[IN_W-1:0];
    end
  end

  assign dpad   = in_data_r[3:0];
  assign fire   = in_data_r[I_FIRE +: FB];
  assign sel    = in_data_r[I_SEL];
  assign start  = in_data_r[I_START];
  assign sw     = in_data_r[I_SW +: FB];
  assign slow   = in_data_r[I_SLOW];
  assign active = in_data_r[I_ACT];

  assign lane_ctl.step   = step;
  assign lane_ctl.active = active;

  for (genvar i = 0; i < FB; i++) begin : g_lane
    gac_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (lane_ctl),
      .hold_cfg   (hold_cfg),
      .switch_bit (sw[i]),
      .held_bit   (fire[i]),
      .fire_bit   (fire_res[i]),
      .mode       (modes[2*i +: 2])
    );
  end

  // slow motion toggle and its free-running pulse
  always_comb begin
    slow_en_nxt  = slow_en_r ^ (active & slow & ~prev_slow_r);
    slow_pulse   = 1'b0;
    slow_cnt_nxt = slow_cnt_r;
    if (slow_en_nxt) begin
      slow_pulse   = gac_pkg::pulse_level(slow_cnt_r, hold_cfg);
      slow_cnt_nxt = gac_pkg::pulse_next(slow_cnt_r, hold_cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_en_r   <= 1'b0;
      slow_cnt_r  <= '0;
      prev_slow_r <= 1'b0;
    end else if (step) begin
      slow_en_r   <= slow_en_nxt;
      slow_cnt_r  <= slow_cnt_nxt;
      prev_slow_r <= slow;
    end
  end

  assign out_data_nxt = {slow_en_nxt, modes, start | slow_pulse, sel, fire_res, dpad};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  // result carries the slow motion state that the same request left behind
  a_slow_on_match : assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (out_tvalid && out_tdata[O_SLOW_ON] == slow_en_r))
    else $error("slow_on in result differs from slow motion state");

  // state only moves when a request is processed
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(slow_en_r) && $stable(slow_cnt_r) && $stable(prev_slow_r)))
    else $error("slow motion state changed without a request");

  // a held request is not dropped while the output stalls
  a_req_kept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_data_r)))
    else $error("pending request lost during output stall");

endmodule

### sim/gac_pad_checker.sv
// ----------------------------------------------------------------------------
// gac_pad_checker
// watches the poll, result and apb channels of the autofire controller, keeps
// its own model of button modes, pulse counters and slow motion, and compares
// every result with the pad state it expects, field by field
// ----------------------------------------------------------------------------
module gac_pad_checker
  import gac_pkg::*;
#(
  parameter int FIRE_N      = FIRE_BUTTONS_DEF,
  parameter int IN_TDATA_W  = 24,
  parameter int OUT_TDATA_W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    polls_in_flight
);

  typedef struct packed {
    logic              act;
    logic              slow;
    logic [FIRE_N-1:0] sw;
    logic              start;
    logic              sel;
    logic [FIRE_N-1:0] fire;
    logic [3:0]        dpad;
  } poll_t;

  typedef struct packed {
    logic                slow_on;
    logic [2*FIRE_N-1:0] modes;
    logic                start;
    logic                sel;
    logic [FIRE_N-1:0]   fire;
    logic [3:0]          dpad;
  } pad_state_t;

  logic [HOLD_W-1:0] hold_high;
  logic [HOLD_W-1:0] hold_low;
  mode_t             fire_mode [FIRE_N];
  logic [CNT_W-1:0]  fire_cnt [FIRE_N];
  logic              sw_prev [FIRE_N];
  logic              slow_en;
  logic [CNT_W-1:0]  slow_cnt;
  logic              slow_prev;

  pad_state_t        expected_pads [$];
  pad_state_t        seen_pad;
  pad_state_t        want_pad;
  logic [HOLD_W-1:0] reg_val;
  int                results_seen;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [2*FIRE_N-1:0] got,
                             input logic [2*FIRE_N-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h expected %h",
                                results_seen, name, got, want));
    end
  endtask

  function automatic mode_t next_mode(mode_t m);
    case (m)
      MODE_OFF:   return MODE_TURBO;
      MODE_TURBO: return MODE_AUTO;
      default:    return MODE_OFF;
    endcase
  endfunction

  function automatic logic pulse_on(logic [CNT_W-1:0] cnt);
    return cnt < hold_high;
  endfunction

  function automatic logic [CNT_W-1:0] pulse_advance(logic [CNT_W-1:0] cnt);
    int nxt;
    nxt = cnt + 1;
    if (nxt >= hold_high + hold_low) begin
      nxt = 0;
    end
    return nxt[CNT_W-1:0];
  endfunction

  // modes and slow motion move first, then the outputs of the same poll
  task automatic advance_pad(input poll_t p, output pad_state_t r);
    logic lvl;
    r      = '0;
    r.dpad = p.dpad;
    r.sel  = p.sel;
    for (int i = 0; i < FIRE_N; i++) begin
      if (p.act && p.sw[i] && !sw_prev[i]) begin
        fire_mode[i] = next_mode(fire_mode[i]);
      end
      sw_prev[i] = p.sw[i];
    end
    if (p.act && p.slow && !slow_prev) begin
      slow_en = !slow_en;
    end
    slow_prev = p.slow;
    for (int i = 0; i < FIRE_N; i++) begin
      case (fire_mode[i])
        MODE_TURBO: begin
          if (p.fire[i]) begin
            lvl         = pulse_on(fire_cnt[i]);
            fire_cnt[i] = pulse_advance(fire_cnt[i]);
          end else begin
            lvl         = 1'b0;
            fire_cnt[i] = '0;
          end
        end
        MODE_AUTO: begin
          lvl         = pulse_on(fire_cnt[i]);
          fire_cnt[i] = pulse_advance(fire_cnt[i]);
        end
        default: begin
          lvl = p.fire[i];
        end
      endcase
      r.fire[i]          = lvl;
      r.modes[2*i +: 2] = fire_mode[i];
    end
    lvl = 1'b0;
    if (slow_en) begin
      lvl      = pulse_on(slow_cnt);
      slow_cnt = pulse_advance(slow_cnt);
    end
    r.start   = p.start | lvl;
    r.slow_on = slow_en;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_high = HOLD_RESET;
      hold_low  = HOLD_RESET;
      for (int i = 0; i < FIRE_N; i++) begin
        fire_mode[i] = MODE_OFF;
        fire_cnt[i]  = '0;
        sw_prev[i]   = 1'b0;
      end
      slow_en   = 1'b0;
      slow_cnt  = '0;
      slow_prev = 1'b0;
      expected_pads.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen_pad = out_tdata[$bits(pad_state_t)-1:0];
        if (expected_pads.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request waiting: %h",
                                    results_seen, out_tdata));
        end else begin
          want_pad = expected_pads.pop_front();
          check_field("dpad_out", (2*FIRE_N)'(seen_pad.dpad),
                      (2*FIRE_N)'(want_pad.dpad));
          check_field("fire_out", (2*FIRE_N)'(seen_pad.fire),
                      (2*FIRE_N)'(want_pad.fire));
          check_field("select_out", (2*FIRE_N)'(seen_pad.sel),
                      (2*FIRE_N)'(want_pad.sel));
          check_field("start_out", (2*FIRE_N)'(seen_pad.start),
                      (2*FIRE_N)'(want_pad.start));
          check_field("modes_out", seen_pad.modes, want_pad.modes);
          check_field("slow_on", (2*FIRE_N)'(seen_pad.slow_on),
                      (2*FIRE_N)'(want_pad.slow_on));
        end
        results_seen++;
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        reg_val = (cfg_paddr[2] == REG_HOLD_HIGH) ? hold_high : hold_low;
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_HOLD_HIGH) begin
            hold_high = cfg_pwdata[HOLD_W-1:0];
          end else begin
            hold_low = cfg_pwdata[HOLD_W-1:0];
          end
        end else if (cfg_prdata !== CFG_DATA_W'(reg_val)) begin
          report_mismatch($sformatf("register read at %h got %h expected %h",
                                    cfg_paddr, cfg_prdata, reg_val));
        end
      end
      if (in_tvalid && in_tready) begin
        advance_pad(poll_t'(in_tdata[$bits(poll_t)-1:0]), want_pad);
        expected_pads.push_back(want_pad);
      end
    end
    polls_in_flight <= expected_pads.size();
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the autofire controller: a short directed opening,
// then phases of hold settings with random pad activity, random gaps on both
// channels and one long output stall; the checker does the comparing
// ----------------------------------------------------------------------------
module tb;
  import gac_pkg::*;

  localparam int FIRE_N       = FIRE_BUTTONS_DEF;
  localparam int IN_BITS      = 8 + 2 * FIRE_N;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((7 + 3 * FIRE_N + 7) / 8) * 8;
  localparam int LONG_HOLD    = 200;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // dpad_raw, fire_raw, select_raw, start_raw, switch_raw, slow_raw, pad_active
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // dpad_out, fire_out, select_out, start_out, modes_out, slow_on
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;

  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int   mismatches;
  int   polls_in_flight;
  int   quiet_cycles = 0;
  int   holds_asked  = 0;
  bit   send_gaps    = 1'b1;
  bit   recv_gaps    = 1'b1;

  logic [FIRE_N-1:0] held_fire   = '0;
  logic [FIRE_N-1:0] held_switch = '0;
  logic              held_slow   = 1'b0;

  always #2 clk = ~clk;

  gamepad_autofire_controller_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  gac_pad_checker #(
    .FIRE_N      (FIRE_N),
    .IN_TDATA_W  (IN_TDATA_W),
    .OUT_TDATA_W (OUT_TDATA_W)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .mismatches      (mismatches),
    .polls_in_flight (polls_in_flight)
  );

  function automatic logic [IN_TDATA_W-1:0] poll_word(
    logic [3:0] dpad, logic [FIRE_N-1:0] fire, logic sel, logic strt,
    logic [FIRE_N-1:0] sw, logic slow, logic act);
    return IN_TDATA_W'({act, slow, sw, strt, sel, fire, dpad});
  endfunction

  function automatic logic [FIRE_N-1:0] rare_mask(int den);
    logic [FIRE_N-1:0] m;
    for (int i = 0; i < FIRE_N; i++) begin
      m[i] = ($urandom_range(0, den - 1) == 0);
    end
    return m;
  endfunction

  // mostly held buttons with occasional presses, some polls pure noise
  task automatic next_poll(output logic [IN_TDATA_W-1:0] w);
    if ($urandom_range(0, 4) == 0) begin
      w = IN_TDATA_W'($urandom_range(0, (1 << IN_BITS) - 1));
    end else begin
      held_fire   ^= rare_mask(5);
      held_switch ^= rare_mask(30);
      if ($urandom_range(0, 39) == 0) begin
        held_slow = !held_slow;
      end
      w = poll_word(4'($urandom_range(0, 15)), held_fire, 1'($urandom_range(0, 1)),
                    $urandom_range(0, 7) == 0, held_switch, held_slow,
                    $urandom_range(0, 15) != 0);
    end
  endtask

  task automatic send_poll(input logic [IN_TDATA_W-1:0] w);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [HOLD_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (polls_in_flight != 0);
  endtask

  task automatic run_phase(input logic [HOLD_W-1:0] hh, input logic [HOLD_W-1:0] hl,
                           input int n, input bit gaps, input bit squeeze);
    logic [IN_TDATA_W-1:0] w;
    wait_idle();
    apb_access(1'b1, REG_HOLD_HIGH, hh);
    apb_access(1'b1, REG_HOLD_LOW, hl);
    apb_access(1'b0, REG_HOLD_HIGH, '0);
    apb_access(1'b0, REG_HOLD_LOW, '0);
    send_gaps = gaps;
    recv_gaps <= gaps;
    if (squeeze) begin
      holds_asked <= holds_asked + 1;
    end
    repeat (n) begin
      next_poll(w);
      send_poll(w);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin : receiver
    int done_holds;
    done_holds = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != done_holds) begin
        done_holds = holds_asked;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gamepad_autofire_controller_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening polls at the reset hold values
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0, 1'b1));
    send_poll(poll_word(4'hf, 6'h3f, 1'b1, 1'b1, 6'h3f, 1'b1, 1'b1));
    send_poll(poll_word(4'h0, 6'h3f, 1'b0, 1'b0, 6'h3f, 1'b1, 1'b1));
    send_poll(poll_word(4'h0, 6'h3f, 1'b0, 1'b0, 6'h3f, 1'b1, 1'b1));
    send_poll(poll_word(4'hf, 6'h3f, 1'b0, 1'b0, 6'h3f, 1'b1, 1'b1));
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b0, 6'h3f, 1'b0, 1'b1));
    send_poll(poll_word(4'h0, 6'h3f, 1'b0, 1'b0, 6'h00, 1'b0, 1'b1));
    send_poll(poll_word(4'h5, 6'h00, 1'b0, 1'b0, 6'h3f, 1'b0, 1'b1));
    send_poll(poll_word(4'ha, 6'h00, 1'b1, 1'b0, 6'h00, 1'b0, 1'b1));
    send_poll(poll_word(4'ha, 6'h00, 1'b1, 1'b0, 6'h00, 1'b0, 1'b1));
    send_poll(poll_word(4'ha, 6'h00, 1'b1, 1'b0, 6'h00, 1'b0, 1'b1));
    // switch and slow edges while inactive are lost
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b0, 6'h3f, 1'b0, 1'b0));
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0, 1'b0));
    send_poll(poll_word(4'h0, 6'h3f, 1'b0, 1'b0, 6'h15, 1'b0, 1'b1));
    send_poll(poll_word(4'h0, 6'h3f, 1'b0, 1'b0, 6'h00, 1'b1, 1'b1));
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b1, 6'h00, 1'b0, 1'b1));
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b0, 6'h00, 1'b1, 1'b0));
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b0, 6'h00, 1'b0, 1'b1));
    send_poll(poll_word(4'h0, 6'h2a, 1'b1, 1'b1, 6'h2a, 1'b0, 1'b1));
    send_poll(poll_word(4'hf, 6'h3f, 1'b1, 1'b0, 6'h00, 1'b1, 1'b1));
    send_poll(poll_word(4'h0, 6'h00, 1'b0, 1'b0, 6'h3f, 1'b1, 1'b1));
    send_poll(poll_word(4'h0, 6'h3f, 1'b0, 1'b0, 6'h00, 1'b0, 1'b1));
    in_tvalid <= 1'b0;

    run_phase(8'd1, 8'd1, 140, 1'b1, 1'b0);
    run_phase(8'd255, 8'd255, 80, 1'b1, 1'b0);
    run_phase(8'd1, 8'd255, 80, 1'b1, 1'b0);
    run_phase(8'd255, 8'd1, 80, 1'b1, 1'b0);
    run_phase(8'd3, 8'd5, 140, 1'b1, 1'b1);
    run_phase(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)), 140, 1'b1, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 100, 1'b1, 1'b0);
    run_phase(8'd2, 8'd3, 140, 1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("gamepad_autofire_controller_unit verification clean");
    end else begin
      $display("gamepad_autofire_controller_unit verification failed");
    end
    $finish;
  end

endmodule
